// ===== rtl/lzss_pkg.sv =====
`timescale 1ns / 1ps

package lzss_pkg;

   localparam int INDEX_BITS_DEF  = 11;
   localparam int LENGTH_BITS_DEF = 4;
   localparam int CMD_FIFO_DEPTH  = 4;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam logic [1:0] CMD_LITERAL = 2'd0;
   localparam logic [1:0] CMD_MATCH   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic       restart;
   } cmd_ctrl_type;

endpackage

// ===== rtl/lzss_front.sv =====
`timescale 1ns / 1ps

module lzss_front #(
   parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
   parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_code_byte,
   input  logic                                req_last_code_byte,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output lzss_pkg::cmd_ctrl_type              cmd_ctrl,
   output logic [INDEX_BITS+LENGTH_BITS-1:0]   cmd_payload
);
   import lzss_pkg::*;

   localparam int ACC_W  = INDEX_BITS + LENGTH_BITS;
   localparam int HELD_W = $clog2(ACC_W + 1);

   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_LIT   = 2'd1;
   localparam logic [1:0] PH_MATCH = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic              tok;
   logic [1:0]        tok_kind;
   logic [ACC_W-1:0]  tok_data;
   logic              fire;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      held_in  = held_ff;
      tok      = 1'b0;
      tok_kind = CMD_LITERAL;
      tok_data = '0;
      for (int b = 7; b >= 0; b--) begin
         if (phase_in != PH_LIT && phase_in != PH_MATCH) begin
            phase_in = req_code_byte[b] ? PH_LIT : PH_MATCH;
            acc_in   = '0;
            held_in  = '0;
         end else begin
            acc_in  = {acc_in[ACC_W-2:0], req_code_byte[b]};
            held_in = held_in + 1'b1;
            if (phase_in == PH_LIT && held_in >= HELD_W'(8)) begin
               tok      = 1'b1;
               tok_kind = CMD_LITERAL;
               tok_data = acc_in;
               phase_in = PH_FLAG;
               acc_in   = '0;
               held_in  = '0;
            end else if (phase_in == PH_MATCH && held_in >= HELD_W'(ACC_W)) begin
               tok      = 1'b1;
               tok_kind = CMD_MATCH;
               tok_data = acc_in;
               phase_in = PH_FLAG;
               acc_in   = '0;
               held_in  = '0;
            end
         end
      end
   end

   assign req_ready        = cmd_ready;
   assign fire             = req_valid && req_ready;
   assign cmd_valid        = fire && (tok || req_last_code_byte);
   assign cmd_ctrl.kind    = tok ? tok_kind : CMD_RESTART;
   assign cmd_ctrl.restart = req_last_code_byte;
   assign cmd_payload      = tok_data;

   always_ff @(posedge clock) begin
      if (reset || (fire && req_last_code_byte)) begin
         phase_ff <= PH_FLAG;
         acc_ff   <= '0;
         held_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         held_ff  <= held_in;
      end
   end

endmodule

// ===== rtl/lzss_cmd_fifo.sv =====
`timescale 1ns / 1ps

module lzss_cmd_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = lzss_pkg::CMD_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             in_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             out_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/lzss_ram.sv =====
`timescale 1ns / 1ps

module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1 << lzss_pkg::INDEX_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== rtl/lzss_back.sv =====
`timescale 1ns / 1ps

module lzss_back #(
   parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
   parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  lzss_pkg::cmd_ctrl_type            cmd_ctrl,
   input  logic [INDEX_BITS+LENGTH_BITS-1:0] cmd_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_run_last
);
   import lzss_pkg::*;

   localparam int DICT_N = 1 << INDEX_BITS;
   localparam int LOOK_F = (1 << LENGTH_BITS) + 1;
   localparam int FILL_W = INDEX_BITS + 1;
   localparam int CNT_W  = LENGTH_BITS + 1;
   localparam logic [INDEX_BITS-1:0] WP_START = INDEX_BITS'(DICT_N - LOOK_F);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                  state_ff, state_in;
   logic [INDEX_BITS-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [INDEX_BITS-1:0] rd_next_ff, rd_next_in;
   logic [CNT_W-1:0]      remain_ff, remain_in;
   logic                  restart_ff, restart_in;
   logic                  rd_written_ff, rd_written_in;
   logic                  rd_space_ff, rd_space_in;
   logic                  rd_bypass_ff, rd_bypass_in;
   logic [7:0]            bypass_data_ff, bypass_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic [7:0]            value;
   logic [7:0]            ram_q;
   logic                  ram_we, ram_re;
   logic [7:0]            ram_wdata;
   logic [INDEX_BITS-1:0] ram_raddr;
   logic                  do_write, do_restart;
   logic [INDEX_BITS-1:0] pos;
   logic [7:0]            literal;

   // An entry counts as written when it lies within the run of writes made
   // since the last restart, which always begins at the start pointer.
   function automatic logic written_at(input logic [INDEX_BITS-1:0] addr,
                                       input logic [FILL_W-1:0] fill);
      logic [INDEX_BITS-1:0] offset;
      offset = addr - WP_START;
      return {1'b0, offset} < fill;
   endfunction

   assign pos      = cmd_payload[LENGTH_BITS +: INDEX_BITS];
   assign literal  = cmd_payload[7:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign value    = rd_bypass_ff ? bypass_data_ff :
                     rd_written_ff ? ram_q :
                     rd_space_ff ? SPACE_CHAR : 8'h00;

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      rd_next_in     = rd_next_ff;
      remain_in      = remain_ff;
      restart_in     = restart_ff;
      rd_written_in  = rd_written_ff;
      rd_space_in    = rd_space_ff;
      rd_bypass_in   = rd_bypass_ff;
      bypass_data_in = bypass_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      cmd_ready      = 1'b0;
      ram_we         = 1'b0;
      ram_wdata      = value;
      ram_re         = 1'b0;
      ram_raddr      = rd_next_ff;
      do_write       = 1'b0;
      do_restart     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_ctrl.kind)
                  CMD_LITERAL: begin
                     if (out_free) begin
                        cmd_ready    = 1'b1;
                        ram_we       = 1'b1;
                        ram_wdata    = literal;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = literal;
                        rsp_last_in  = 1'b1;
                        do_write     = 1'b1;
                        do_restart   = cmd_ctrl.restart;
                     end
                  end
                  CMD_MATCH: begin
                     cmd_ready     = 1'b1;
                     ram_re        = 1'b1;
                     ram_raddr     = pos;
                     rd_written_in = written_at(pos, fill_ff);
                     rd_space_in   = pos < WP_START;
                     rd_bypass_in  = 1'b0;
                     rd_next_in    = pos + 1'b1;
                     remain_in     = CNT_W'(cmd_payload[LENGTH_BITS-1:0]) + CNT_W'(2);
                     restart_in    = cmd_ctrl.restart;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                     cmd_ready  = 1'b1;
                     do_restart = 1'b1;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ram_we       = 1'b1;
               ram_wdata    = value;
               rsp_valid_in = 1'b1;
               rsp_data_in  = value;
               rsp_last_in  = remain_ff == CNT_W'(1);
               do_write     = 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in   = ST_IDLE;
                  do_restart = restart_ff;
               end else begin
                  // A read of the address written in this cycle takes the
                  // byte straight from the write side.
                  ram_re         = 1'b1;
                  ram_raddr      = rd_next_ff;
                  rd_bypass_in   = rd_next_ff == wp_ff;
                  bypass_data_in = value;
                  rd_written_in  = written_at(rd_next_ff, fill_ff);
                  rd_space_in    = rd_next_ff < WP_START;
                  rd_next_in     = rd_next_ff + 1'b1;
                  remain_in      = remain_ff - 1'b1;
               end
            end
         end
      endcase

      if (do_write) begin
         wp_in   = wp_ff + 1'b1;
         fill_in = (fill_ff == FILL_W'(DICT_N)) ? fill_ff : fill_ff + 1'b1;
      end
      if (do_restart) begin
         wp_in   = WP_START;
         fill_in = '0;
      end
   end

   lzss_ram #(
      .WIDTH (8),
      .DEPTH (DICT_N)
   ) u_dict (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= WP_START;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_next_ff     <= rd_next_in;
      remain_ff      <= remain_in;
      restart_ff     <= restart_in;
      rd_written_ff  <= rd_written_in;
      rd_space_ff    <= rd_space_in;
      rd_bypass_ff   <= rd_bypass_in;
      bypass_data_ff <= bypass_data_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_run_last  = rsp_last_ff;

endmodule

// ===== rtl/lzss_decompressor_unit.sv =====
`timescale 1ns / 1ps
// LZSS decompressor with a 2^INDEX_BITS byte dictionary.
// The req channel takes one compressed byte per beat, with req_last_code_byte
// marking the final byte of a stream. The rsp channel gives one decoded byte
// per beat; rsp_run_last marks the final byte of each token, so it is set on
// every literal and on the last byte of each copy.
// A front stage splits a whole input byte into tokens combinationally and takes
// a byte every cycle while its command queue has room. The back stage runs
// the dictionary: a literal is written to it as it enters the output register;
// a copy of L+2 bytes issues its first read when the token is taken, with one
// dictionary read and write per byte. A match token of two input bytes thus
// gives up to 2^LENGTH_BITS+1 bytes. A literal passes the command queue and
// the output register, and the first byte of a copy also the dictionary read.
// Reset empties the queue and output register and puts the dictionary in its
// initial state at once, with no clearing pass. After the final byte of a
// stream, once its tokens are delivered, the same initial state returns.
// When the receiver holds rsp_ready low, the output register holds its byte,
// the back stage waits, the queue fills and req_ready then falls.

module lzss_decompressor_unit #(
   parameter int INDEX_BITS  = lzss_pkg::INDEX_BITS_DEF,
   parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   input  logic       req_last_code_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_run_last
);
   import lzss_pkg::*;

   localparam int ACC_W  = INDEX_BITS + LENGTH_BITS;
   localparam int CTRL_W = $bits(cmd_ctrl_type);

   logic                    push_valid, push_ready;
   cmd_ctrl_type            push_ctrl;
   logic [ACC_W-1:0]        push_payload;
   logic                    head_valid, head_pop;
   logic [CTRL_W+ACC_W-1:0] head_data;
   cmd_ctrl_type            head_ctrl;
   logic [ACC_W-1:0]        head_payload;

   lzss_front #(
      .INDEX_BITS  (INDEX_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_byte      (req_code_byte),
      .req_last_code_byte (req_last_code_byte),
      .cmd_valid          (push_valid),
      .cmd_ready          (push_ready),
      .cmd_ctrl           (push_ctrl),
      .cmd_payload        (push_payload)
   );

   lzss_cmd_fifo #(
      .WIDTH (CTRL_W + ACC_W),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .in_ready  (push_ready),
      .push_data ({push_ctrl, push_payload}),
      .out_valid (head_valid),
      .pop       (head_pop),
      .pop_data  (head_data)
   );

   assign head_ctrl    = head_data[CTRL_W+ACC_W-1:ACC_W];
   assign head_payload = head_data[ACC_W-1:0];

   lzss_back #(
      .INDEX_BITS  (INDEX_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (head_valid),
      .cmd_ready     (head_pop),
      .cmd_ctrl      (head_ctrl),
      .cmd_payload   (head_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_byte (rsp_data_byte),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ===== rtl/lzss_checker.sv =====
`timescale 1ns / 1ps

module lzss_checker #(
   parameter int LENGTH_BITS = lzss_pkg::LENGTH_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_run_last
);
   localparam int RUN_W = LENGTH_BITS + 1;

   logic [RUN_W-1:0] run_cnt_ff;
   logic             rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= '0;
      end else if (rsp_fire) begin
         run_cnt_ff <= rsp_run_last ? '0 : run_cnt_ff + 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
                                  && $stable(rsp_run_last))
      else $error("result beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_run_last |-> run_cnt_ff < RUN_W'(1 << LENGTH_BITS))
      else $error("copy run longer than the longest match");

   a_run_closed_at_reset: assert property (@(posedge clock)
      reset |=> run_cnt_ff == '0)
      else $error("run count not cleared by reset");

endmodule

bind lzss_decompressor_unit lzss_checker #(
   .LENGTH_BITS (LENGTH_BITS)
) u_checker (.*);
